// ===== rtl/core/afc_pkg.sv =====
package afc_pkg;

    localparam int unsigned DEFAULT_FRAC_BITS = 16;
    localparam int unsigned Q_WIDTH           = 32;
    localparam int unsigned COEF_WIDTH        = Q_WIDTH + 1;
    localparam int unsigned PROD_WIDTH        = 2 * COEF_WIDTH;
    localparam int unsigned NUM_ENTRIES       = 6;

    typedef logic signed [Q_WIDTH-1:0]    q_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;

    typedef enum logic [2:0] {
        ACT_IDENTITY  = 3'd0,
        ACT_TRANSLATE = 3'd1,
        ACT_SCALE     = 3'd2,
        ACT_ROTATE    = 3'd3,
        ACT_REFLECT_X = 3'd4,
        ACT_VERTEX    = 3'd5
    } action_t;

endpackage

// ===== rtl/core/affine_2d_transform_composer_core.sv =====
// 2D homogeneous transform composer.
// Input channel (in_valid/in_ready) carries one beat per action: action,
// operand_a, operand_b and last_vertex. Actions load identity, premultiply the
// stored 2x3 matrix by a translation, scale, rotation or x-axis reflection, or
// transform one vertex. Only a vertex beat produces an output beat on the
// output channel (out_valid/out_ready) with x_out, y_out and last_out.
// A beat is captured in an input register; from there twelve parallel
// multipliers in six afc_dot units, each summing two products and an addend,
// update the matrix register or load the output register. One beat per cycle
// is sustained while the receiver keeps up; the matrix register is the only
// loop, closed through the afc_dot units. Reset loads the identity matrix and
// empties both registers. When the receiver stalls, a held vertex result still
// lets matrix actions pass; a second vertex waits in the input register and
// in_ready drops only then.
module affine_2d_transform_composer_core #(
    parameter int unsigned FRAC_BITS = afc_pkg::DEFAULT_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    action,
    input  afc_pkg::q_t   operand_a,
    input  afc_pkg::q_t   operand_b,
    input  logic          last_vertex,
    output logic          out_valid,
    input  logic          out_ready,
    output afc_pkg::q_t   x_out,
    output afc_pkg::q_t   y_out,
    output logic          last_out
);
    import afc_pkg::*;

    localparam q_t    ONE_Q    = q_t'(1) <<< FRAC_BITS;
    localparam coef_t ONE_C    = coef_t'(ONE_Q);
    localparam coef_t NEG_ONE_C = -ONE_C;

    logic          stage_valid_reg;
    logic [2:0]    act_reg;
    q_t            opa_reg;
    q_t            opb_reg;
    logic          lastv_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    q_t            x_reg;
    q_t            y_reg;
    logic          last_out_reg;

    q_t            m_reg  [NUM_ENTRIES];
    q_t            m_next [NUM_ENTRIES];

    coef_t         mul_a0 [NUM_ENTRIES];
    coef_t         mul_a1 [NUM_ENTRIES];
    coef_t         mul_b0 [NUM_ENTRIES];
    coef_t         mul_b1 [NUM_ENTRIES];
    q_t            addend [NUM_ENTRIES];
    q_t            dot    [NUM_ENTRIES];

    coef_t         cu;
    coef_t         cv;
    coef_t         cw;
    coef_t         cz;
    q_t            add_top;
    q_t            add_bot;
    logic          is_vertex;
    logic          out_free;
    logic          advance;
    logic          update_m;

    assign is_vertex = (act_reg == ACT_VERTEX);
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = stage_valid_reg && (!is_vertex || out_free);
    assign in_ready  = !stage_valid_reg || !is_vertex || out_free;

    always_comb
    begin
        cu       = '0;
        cv       = '0;
        cw       = '0;
        cz       = '0;
        add_top  = '0;
        add_bot  = '0;
        update_m = 1'b0;
        case (action_t'(act_reg))
            ACT_TRANSLATE:
            begin
                cu       = ONE_C;
                cz       = ONE_C;
                add_top  = opa_reg;
                add_bot  = opb_reg;
                update_m = 1'b1;
            end
            ACT_SCALE:
            begin
                cu       = coef_t'(opa_reg);
                cz       = coef_t'(opb_reg);
                update_m = 1'b1;
            end
            ACT_ROTATE:
            begin
                cu       = coef_t'(opa_reg);
                cv       = -coef_t'(opb_reg);
                cw       = coef_t'(opb_reg);
                cz       = coef_t'(opa_reg);
                update_m = 1'b1;
            end
            ACT_REFLECT_X:
            begin
                cu       = ONE_C;
                cz       = NEG_ONE_C;
                update_m = 1'b1;
            end
            default:
            begin
                update_m = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            mul_a0[j]     = cu;
            mul_a1[j]     = coef_t'(m_reg[j]);
            mul_b0[j]     = cv;
            mul_b1[j]     = coef_t'(m_reg[3+j]);
            addend[j]     = (j == 2) ? add_top : '0;
            mul_a0[3+j]   = cw;
            mul_a1[3+j]   = coef_t'(m_reg[j]);
            mul_b0[3+j]   = cz;
            mul_b1[3+j]   = coef_t'(m_reg[3+j]);
            addend[3+j]   = (j == 2) ? add_bot : '0;
        end
        if (is_vertex)
        begin
            mul_a0[0] = coef_t'(opa_reg);
            mul_a1[0] = coef_t'(m_reg[0]);
            mul_b0[0] = coef_t'(opb_reg);
            mul_b1[0] = coef_t'(m_reg[1]);
            addend[0] = m_reg[2];
            mul_a0[3] = coef_t'(opa_reg);
            mul_a1[3] = coef_t'(m_reg[3]);
            mul_b0[3] = coef_t'(opb_reg);
            mul_b1[3] = coef_t'(m_reg[4]);
            addend[3] = m_reg[5];
        end
    end

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_dot
        afc_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_dot (
            .mul_a0 (mul_a0[k]),
            .mul_a1 (mul_a1[k]),
            .mul_b0 (mul_b0[k]),
            .mul_b1 (mul_b1[k]),
            .addend (addend[k]),
            .result (dot[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            m_next[k] = m_reg[k];
        end
        if (advance)
        begin
            if (act_reg == ACT_IDENTITY)
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                begin
                    m_next[k] = '0;
                end
                m_next[0] = ONE_Q;
                m_next[4] = ONE_Q;
            end
            else if (update_m)
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                begin
                    m_next[k] = dot[k];
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && is_vertex)
        begin
            out_valid_next = 1'b1;
        end
    end

    // input stage: advance on accept, drop once the beat has been used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= action;
            opa_reg   <= operand_a;
            opb_reg   <= operand_b;
            lastv_reg <= last_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                m_reg[k] <= (k == 0 || k == 4) ? ONE_Q : '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                m_reg[k] <= m_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (advance && is_vertex)
        begin
            x_reg        <= dot[0];
            y_reg        <= dot[3];
            last_out_reg <= lastv_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign last_out  = last_out_reg;

endmodule

// ===== rtl/core/afc_dot.sv =====
module afc_dot #(
    parameter int unsigned FRAC_BITS = afc_pkg::DEFAULT_FRAC_BITS
) (
    input  afc_pkg::coef_t mul_a0,
    input  afc_pkg::coef_t mul_a1,
    input  afc_pkg::coef_t mul_b0,
    input  afc_pkg::coef_t mul_b1,
    input  afc_pkg::q_t    addend,
    output afc_pkg::q_t    result
);
    import afc_pkg::*;

    localparam prod_t HALF  = prod_t'(1) <<< (FRAC_BITS - 1);
    localparam prod_t Q_MAX = prod_t'({1'b0, {(Q_WIDTH-1){1'b1}}});
    localparam prod_t Q_MIN = -Q_MAX - prod_t'(1);

    prod_t prod_a;
    prod_t prod_b;
    prod_t rnd_a;
    prod_t rnd_b;
    prod_t sum;

    assign prod_a = prod_t'(mul_a0) * prod_t'(mul_a1);
    assign prod_b = prod_t'(mul_b0) * prod_t'(mul_b1);
    assign rnd_a  = (prod_a + HALF) >>> FRAC_BITS;
    assign rnd_b  = (prod_b + HALF) >>> FRAC_BITS;
    assign sum    = rnd_a + rnd_b + prod_t'(addend);

    always_comb
    begin
        if (sum > Q_MAX)
        begin
            result = q_t'(Q_MAX);
        end
        else if (sum < Q_MIN)
        begin
            result = q_t'(Q_MIN);
        end
        else
        begin
            result = q_t'(sum);
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int unsigned FB           = DEFAULT_FRAC_BITS;
    localparam longint      ONE_Q        = longint'(1) << FB;
    localparam longint      HALF_Q       = longint'(1) << (FB - 1);
    localparam longint      SAT_MAX      = 64'sd2147483647;
    localparam longint      SAT_MIN      = -64'sd2147483648;
    localparam q_t          Q_ONE        = q_t'(ONE_Q);
    localparam q_t          Q_HALF       = q_t'(HALF_Q);
    localparam q_t          Q_MAX        = 32'sh7FFF_FFFF;
    localparam q_t          Q_MIN        = 32'sh8000_0000;
    localparam logic [2:0]  ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0]  ACT_UNUSED_7 = 3'd7;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        q_t   x;
        q_t   y;
        logic lst;
    } vertex_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [2:0] action      = ACT_IDENTITY;
    q_t         operand_a   = '0;
    q_t         operand_b   = '0;
    logic       last_vertex = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    q_t         x_out;
    q_t         y_out;
    logic       last_out;

    longint      xform_mtx [6] = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
    vertex_t     vertex_q [$];
    vertex_t     want;
    int unsigned errors           = 0;
    int unsigned beats_sent       = 0;
    int unsigned vertices_checked = 0;
    int unsigned cycles           = 0;
    int unsigned tx_idle_pct      = 0;
    int unsigned rx_idle_pct      = 0;
    int unsigned hold_req         = 0;
    int unsigned hold_ack         = 0;
    int unsigned hold_left        = 0;

    affine_2d_transform_composer_core #(
        .FRAC_BITS(FB)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .last_vertex(last_vertex),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_out      (x_out),
        .y_out      (y_out),
        .last_out   (last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t ns: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint round_mul(longint a, longint b);
        return (a * b + HALF_Q) >>> FB;
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    function automatic void premultiply_by(longint l00, longint l01, longint l02,
                                           longint l10, longint l11, longint l12);
        longint prev [6];
        longint top;
        longint bot;
        prev = xform_mtx;
        for (int j = 0; j < 3; j++)
        begin
            top = round_mul(l00, prev[j]) + round_mul(l01, prev[3 + j]);
            bot = round_mul(l10, prev[j]) + round_mul(l11, prev[3 + j]);
            if (j == 2)
            begin
                top += l02;
                bot += l12;
            end
            xform_mtx[j]     = clamp_q(top);
            xform_mtx[3 + j] = clamp_q(bot);
        end
    endfunction

    function automatic void apply_action(logic [2:0] act, q_t a, q_t b, logic lst);
        longint  sa;
        longint  sb;
        vertex_t v;
        sa = a;
        sb = b;
        case (act)
            ACT_IDENTITY:  xform_mtx = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
            ACT_TRANSLATE: premultiply_by(ONE_Q, 0, sa, 0, ONE_Q, sb);
            ACT_SCALE:     premultiply_by(sa, 0, 0, 0, sb, 0);
            ACT_ROTATE:    premultiply_by(sa, -sb, 0, sb, sa, 0);
            ACT_REFLECT_X: premultiply_by(ONE_Q, 0, 0, 0, -ONE_Q, 0);
            ACT_VERTEX:
            begin
                v.x   = q_t'(clamp_q(round_mul(xform_mtx[0], sa)
                                     + round_mul(xform_mtx[1], sb) + xform_mtx[2]));
                v.y   = q_t'(clamp_q(round_mul(xform_mtx[3], sa)
                                     + round_mul(xform_mtx[4], sb) + xform_mtx[5]));
                v.lst = lst;
                vertex_q.push_back(v);
            end
            default: ;
        endcase
    endfunction

    // check results before predicting, so a beat never meets its own result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (vertex_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: vertex with nothing pending: x=%h y=%h last=%b",
                             $time, x_out, y_out, last_out);
                end
                else
                begin
                    want = vertex_q.pop_front();
                    vertices_checked++;
                    if (x_out !== want.x)
                    begin
                        errors++;
                        $display("%0t ns: x_out expected %h actual %h", $time, want.x, x_out);
                    end
                    if (y_out !== want.y)
                    begin
                        errors++;
                        $display("%0t ns: y_out expected %h actual %h", $time, want.y, y_out);
                    end
                    if (last_out !== want.lst)
                    begin
                        errors++;
                        $display("%0t ns: last_out expected %b actual %b",
                                 $time, want.lst, last_out);
                    end
                end
            end
            if (in_valid && in_ready)
                apply_action(action, operand_a, operand_b, last_vertex);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic q_t rand_span(int unsigned span);
        return q_t'(longint'($urandom_range(2 * span)) - longint'(span));
    endfunction

    task automatic send_beat(input logic [2:0] act, input q_t a, input q_t b,
                             input logic lst);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        operand_a   <= a;
        operand_b   <= b;
        last_vertex <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act <= ACT_VERTEX)
            beats_sent++;
    endtask

    task automatic drain_vertices();
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertex_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic test_directed();
        send_beat(ACT_VERTEX, Q_ONE, -Q_ONE, 1'b0);
        send_beat(ACT_VERTEX, Q_MAX, Q_MIN, 1'b1);
        send_beat(ACT_VERTEX, Q_MIN, Q_MAX, 1'b0);
        send_beat(ACT_IDENTITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(ACT_TRANSLATE, Q_MAX, Q_MIN, 1'b1);
        send_beat(ACT_VERTEX, '0, '0, 1'b0);
        // push the offsets past full scale
        send_beat(ACT_TRANSLATE, Q_MAX, Q_MIN, 1'b0);
        send_beat(ACT_VERTEX, Q_ONE, Q_ONE, 1'b1);
        send_beat(ACT_IDENTITY, Q_ONE, Q_MIN, 1'b0);
        send_beat(ACT_SCALE, Q_MIN, Q_MIN, 1'b0);
        // negating the most negative entry must saturate high
        send_beat(ACT_REFLECT_X, Q_MAX, Q_MAX, 1'b1);
        send_beat(ACT_VERTEX, Q_MAX, Q_MAX, 1'b0);
        send_beat(ACT_VERTEX, Q_MIN, Q_MIN, 1'b1);
        send_beat(ACT_IDENTITY, '0, '0, 1'b0);
        send_beat(ACT_ROTATE, '0, Q_MIN, 1'b0);
        send_beat(ACT_VERTEX, Q_ONE, Q_ONE, 1'b0);
        send_beat(ACT_UNUSED_6, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1);
        send_beat(ACT_UNUSED_7, 32'hFFFF_FFFF, '0, 1'b1);
        send_beat(ACT_VERTEX, -q_t'(1), '0, 1'b1);
        send_beat(ACT_ROTATE, Q_MAX, Q_MAX, 1'b0);
        send_beat(ACT_SCALE, Q_HALF, -q_t'(1), 1'b1);
        send_beat(ACT_VERTEX, q_t'(3), -q_t'(3), 1'b0);
        send_beat(ACT_REFLECT_X, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(ACT_VERTEX, Q_MAX, Q_MIN, 1'b1);
        drain_vertices();
    endtask

    task automatic send_polygon();
        int unsigned n_ops;
        int unsigned n_verts;
        n_ops   = $urandom_range(4);
        n_verts = $urandom_range(1, 8);
        if ($urandom_range(3) != 0)
            send_beat(ACT_IDENTITY, $urandom, $urandom, 1'($urandom_range(1)));
        repeat (n_ops)
        begin
            case ($urandom_range(3))
                0: send_beat(ACT_TRANSLATE, rand_span(1 << 24), rand_span(1 << 24),
                             1'($urandom_range(1)));
                1: send_beat(ACT_SCALE, rand_span(4 << FB), rand_span(4 << FB),
                             1'($urandom_range(1)));
                2: send_beat(ACT_ROTATE, rand_span(1 << FB), rand_span(1 << FB),
                             1'($urandom_range(1)));
                default: send_beat(ACT_REFLECT_X, $urandom, $urandom,
                                   1'($urandom_range(1)));
            endcase
        end
        for (int i = 0; i < n_verts; i++)
            send_beat(ACT_VERTEX, rand_span(1 << 22), rand_span(1 << 22),
                      (i == n_verts - 1));
    endtask

    task automatic test_polygon_stream(input int unsigned n_beats);
        int unsigned target;
        target = beats_sent + n_beats;
        while (beats_sent < target)
        begin
            if ($urandom_range(5) == 0)
                send_beat(3'($urandom_range(7)), $urandom, $urandom,
                          1'($urandom_range(1)));
            else
                send_polygon();
        end
        drain_vertices();
    endtask

    // stall the output long enough that the input side backs up
    task automatic test_output_stall();
        set_idle(0, 0);
        hold_req <= hold_req + 1;
        repeat (70)
        begin
            if ($urandom_range(4) == 0)
                send_beat(ACT_TRANSLATE, rand_span(1 << 20), rand_span(1 << 20), 1'b0);
            else
                send_beat(ACT_VERTEX, $urandom, $urandom, 1'($urandom_range(1)));
        end
        drain_vertices();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_idle(38, 82);
        test_polygon_stream(550);
        set_idle(82, 38);
        test_polygon_stream(550);
        set_idle(0, 0);
        test_polygon_stream(550);
        test_output_stall();
        repeat (10) @(posedge clk);
        $display("Covered %0d beats (all actions, unused codes, saturating extremes),",
                 beats_sent);
        $display("%0d vertices checked under three idle mixes and a %0d-cycle output stall.",
                 vertices_checked, HOLD_CYCLES);
        if (errors == 0 && vertex_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
